// ===== src/ecfs_pkg.sv =====
package ecfs_pkg;

  // Frame text characters.
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_ESC = 8'h5C;
  localparam logic [7:0] CHAR_S   = 8'd115;
  localparam logic [7:0] CHAR_N   = 8'd110;
  localparam logic [7:0] CHAR_P   = 8'd112;

  // Item opcodes.
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  // Data bytes carried by the first frame of a split packet.
  localparam int unsigned FIRST_FRAME_DATA = 12;
  localparam logic [5:0] FIRST_FRAME_CNT = 6'(FIRST_FRAME_DATA);

  // Checksum seed: the characters "snp".
  localparam logic [15:0] SUM_SEED = 16'(115 + 110 + 112);

  // Frame prefix "BC:DT=", one character per index.
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h42;
      3'd1:    c = 8'h43;
      3'd2:    c = 8'h3A;
      3'd3:    c = 8'h44;
      3'd4:    c = 8'h54;
      default: c = 8'h3D;
    endcase
    return c;
  endfunction

endpackage

// ===== src/ecfs_in_if.sv =====
interface ecfs_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] pkt_type;
  logic [7:0] pkt_address;
  logic [5:0] pkt_length;
  logic [7:0] data_byte;

  modport source (
    output valid, op, pkt_type, pkt_address, pkt_length, data_byte,
    input  ready
  );
  modport sink (
    input  valid, op, pkt_type, pkt_address, pkt_length, data_byte,
    output ready
  );
endinterface

// ===== src/ecfs_out_if.sv =====
interface ecfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       last;

  modport source (
    output valid, out_byte, frame_end, last,
    input  ready
  );
  modport sink (
    input  valid, out_byte, frame_end, last,
    output ready
  );
endinterface

// ===== src/escaped_checksum_frame_splitter.sv =====
// Escaped checksum frame splitter.
// The input channel in_i carries packet items: a header (op 0) with type, address and
// data length, then one data item (op 1) per payload byte. The output channel out_o
// carries the radio frame text one byte per transfer; frame_end marks the closing LF
// of each frame and last marks the final byte caused by one input item.
// Each accepted header or in-packet data item is registered as a short descriptor. An
// emitter then walks the descriptor and, unless the receiver stalls, loads one text
// byte per cycle into the output register, which drives out_o.
// Throughput: one output byte per cycle while the receiver keeps up; an item yields
// 1 to 15 result bytes, and typical data bytes yield 1 or 2 of them. A new
// item is accepted in the cycle in which the previous item's last byte enters the
// output register, so items flow back to back without idle cycles.
// Data items outside an open packet are accepted and produce nothing.
// Reset clears the packet state, the descriptor and the output register.
// When the receiver stalls, the output register holds its byte, the emitter waits, and
// in_i.ready falls once the descriptor stage is also full.
module escaped_checksum_frame_splitter
  import ecfs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  ecfs_in_if.sink           in_i,
  ecfs_out_if.source        out_o
);

  typedef enum logic [2:0] {
    SEG_HDR,
    SEG_ESC,
    SEG_DAT,
    SEG_SPL,
    SEG_TAL
  } seg_e;

  localparam logic [3:0] HDR_LAST = 4'd10;
  localparam logic [3:0] SPL_LAST = 4'd7;
  localparam logic [3:0] TAL_LAST = 4'd3;

  // Packet state.
  logic        in_packet_q, in_packet_d;
  logic [5:0]  expected_length_q, expected_length_d;
  logic [5:0]  byte_count_q, byte_count_d;
  logic [15:0] running_sum_q, running_sum_d;

  // Descriptor stage.
  logic        desc_valid_q;
  seg_e        seg_q;
  logic [3:0]  idx_q;
  logic [7:0]  typ_q, adr_q, dat_q;
  logic [15:0] sum_q;
  logic        tail_q, split_q;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_fe_q, out_last_q;

  // Handshake and emitter control.
  logic        accept, produce, data_ok, emit, load_ok, desc_free;
  logic        hdr_item, esc_d, tail_d, split_d;
  logic [5:0]  cnt_next;
  seg_e        seg_start;
  logic [7:0]  byte_sel;
  logic        fe_sel, seg_end, done;
  seg_e        seg_next;
  logic [3:0]  idx_m2;

  // Input side: decode the item and update the packet state.
  assign hdr_item = (in_i.op == OP_HEADER);
  assign cnt_next = byte_count_q + 6'd1;
  assign data_ok  = in_packet_q && (byte_count_q < expected_length_q);
  assign esc_d    = (in_i.data_byte == CHAR_CR) || (in_i.data_byte == CHAR_LF) ||
                    (in_i.data_byte == CHAR_ESC);

  always_comb begin
    in_packet_d       = in_packet_q;
    expected_length_d = expected_length_q;
    byte_count_d      = byte_count_q;
    running_sum_d     = running_sum_q;
    tail_d            = 1'b0;
    split_d           = 1'b0;
    seg_start         = SEG_HDR;
    if (hdr_item) begin
      running_sum_d     = SUM_SEED + {8'd0, in_i.pkt_type} + {8'd0, in_i.pkt_address};
      expected_length_d = in_i.pkt_length;
      byte_count_d      = '0;
      tail_d            = (in_i.pkt_length == 6'd0);
      in_packet_d       = !tail_d;
    end else begin
      running_sum_d = running_sum_q + {8'd0, in_i.data_byte};
      byte_count_d  = cnt_next;
      tail_d        = (cnt_next == expected_length_q);
      split_d       = !tail_d && (cnt_next == FIRST_FRAME_CNT);
      in_packet_d   = !tail_d;
      seg_start     = esc_d ? SEG_ESC : SEG_DAT;
    end
  end

  assign load_ok   = !out_valid_q || out_o.ready;
  assign emit      = desc_valid_q && load_ok;
  assign desc_free = !desc_valid_q || (emit && done);
  assign accept    = in_i.valid && desc_free;
  assign produce   = accept && (hdr_item || data_ok);
  assign in_i.ready = desc_free;

  // Emitter: pick the byte at the current segment position and find the next one.
  assign idx_m2 = idx_q - 4'd2;

  always_comb begin
    byte_sel = CHAR_LF;
    fe_sel   = 1'b0;
    seg_end  = 1'b1;
    done     = 1'b1;
    seg_next = SEG_TAL;
    case (seg_q)
      SEG_HDR: begin
        if (idx_q < 4'd6) begin
          byte_sel = prefix_char(idx_q[2:0]);
        end else begin
          case (idx_q)
            4'd6:    byte_sel = CHAR_S;
            4'd7:    byte_sel = CHAR_N;
            4'd8:    byte_sel = CHAR_P;
            4'd9:    byte_sel = typ_q;
            default: byte_sel = adr_q;
          endcase
        end
        seg_end = (idx_q == HDR_LAST);
        done    = seg_end && !tail_q;
      end
      SEG_ESC: begin
        byte_sel = CHAR_ESC;
        done     = 1'b0;
        seg_next = SEG_DAT;
      end
      SEG_DAT: begin
        byte_sel = dat_q;
        done     = !tail_q && !split_q;
        seg_next = tail_q ? SEG_TAL : SEG_SPL;
      end
      SEG_SPL: begin
        case (idx_q)
          4'd0:    byte_sel = CHAR_CR;
          4'd1:    byte_sel = CHAR_LF;
          default: byte_sel = prefix_char(idx_m2[2:0]);
        endcase
        fe_sel  = (idx_q == 4'd1);
        seg_end = (idx_q == SPL_LAST);
        done    = seg_end;
      end
      SEG_TAL: begin
        case (idx_q)
          4'd0:    byte_sel = sum_q[15:8];
          4'd1:    byte_sel = sum_q[7:0];
          4'd2:    byte_sel = CHAR_CR;
          default: byte_sel = CHAR_LF;
        endcase
        fe_sel  = (idx_q == TAL_LAST);
        seg_end = (idx_q == TAL_LAST);
        done    = seg_end;
      end
      default: begin
        byte_sel = CHAR_LF;
      end
    endcase
  end

  // State, descriptor sequencing, descriptor payload and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q       <= 1'b0;
      expected_length_q <= '0;
      byte_count_q      <= '0;
      running_sum_q     <= '0;
      desc_valid_q      <= 1'b0;
      seg_q             <= SEG_HDR;
      idx_q             <= '0;
      typ_q             <= '0;
      adr_q             <= '0;
      dat_q             <= '0;
      sum_q             <= '0;
      tail_q            <= 1'b0;
      split_q           <= 1'b0;
      out_valid_q       <= 1'b0;
      out_byte_q        <= '0;
      out_fe_q          <= 1'b0;
      out_last_q        <= 1'b0;
    end else begin
      if (produce) begin
        in_packet_q       <= in_packet_d;
        expected_length_q <= expected_length_d;
        byte_count_q      <= byte_count_d;
        running_sum_q     <= running_sum_d;
      end
      if (produce) begin
        desc_valid_q <= 1'b1;
        seg_q        <= seg_start;
        idx_q        <= '0;
        typ_q        <= in_i.pkt_type;
        adr_q        <= in_i.pkt_address;
        dat_q        <= in_i.data_byte;
        sum_q        <= running_sum_d;
        tail_q       <= tail_d;
        split_q      <= split_d;
      end else if (emit) begin
        if (done) begin
          desc_valid_q <= 1'b0;
        end else if (seg_end) begin
          seg_q <= seg_next;
          idx_q <= '0;
        end else begin
          idx_q <= idx_q + 4'd1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
        out_byte_q  <= byte_sel;
        out_fe_q    <= fe_sel;
        out_last_q  <= done;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.frame_end = out_fe_q;
  assign out_o.last      = out_last_q;

`ifndef SYNTHESIS
  // An open packet always has data bytes still to come.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_packet_q |-> (byte_count_q < expected_length_q))
    else $error("open packet has no bytes left");

  // A frame always closes on a line feed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_fe_q) |-> (out_byte_q == CHAR_LF))
    else $error("frame end on a byte other than LF");

  // The bytes of one item follow each other without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.ready && !out_last_q) |=> out_valid_q)
    else $error("gap inside the bytes of one item");
`endif

endmodule
